/* rtl/bcpa_pkg.sv */
// Shared types and constants of the contiguous page allocator.
package bcpa_pkg;

  localparam int CntW    = 13;
  localparam int FrameW  = 32;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_BASE_FRAME = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_POOL_SIZE  = 2'd1;

  typedef struct packed {
    logic [CntW-1:0] page_count;
    logic            want_aligned;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [FrameW:0]   first_frame;
    logic [CntW-1:0]   granted_count;
  } rsp_t;

endpackage

/* rtl/bitmap_contiguous_page_allocator_unit.sv */
// Contiguous page allocator: next-fit search over a one-bit-per-page usage map.
//
// A request (req_valid/req_stall/req_data) asks for page_count contiguous pages,
// optionally aligned to their own size in absolute frame numbers. The result
// (rsp_valid/rsp_stall/rsp_data) reports granted, the first frame and the count.
// The user must write configuration (cfg_we/cfg_index/cfg_data) only while idle;
// this is not enforced. A pool_size write restarts the pool and clears the map.
//
// The block works on one request at a time. A shared restoring remainder unit
// computes the offsets: one modulo for the first start of an unaligned request,
// two for an aligned one, and one more for every candidate run that an aligned
// request checks. The map is scanned one page per cycle with a registered read;
// a grant then marks the run used page by page and loads the output register.
// Zero-page requests and requests made while no page is free skip the search and
// go straight to the output register.
// After reset, and after each pool_size write, a clearing pass runs over all
// MAX_PAGES entries of the map before the first request is taken.
// The result sits in an output register; while the receiver stalls, it waits
// there, and the following request may run but holds its result until then.
module bitmap_contiguous_page_allocator_unit
  import bcpa_pkg::*;
#(
  parameter int MAX_PAGES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req_data,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [FrameW-1:0]  cfg_data
);

  localparam int IW = $clog2(MAX_PAGES);
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int VW = ((CW > CntW) ? CW : CntW) + 1;
  localparam logic [VW-1:0] MaxV = VW'(MAX_PAGES);
  localparam logic [IW-1:0] LastAddr = IW'(MAX_PAGES - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_SCAN0 = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_MARK = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // What to do when the remainder unit finishes.
  localparam logic [1:0] R_START = 2'd0;
  localparam logic [1:0] R_CURR  = 2'd1;
  localparam logic [1:0] R_RUN   = 2'd2;

  logic [2:0]        state;
  logic [FrameW-1:0] base_frame;
  logic [CntW-1:0]   pool_size;
  logic [CntW-1:0]   free_pages;
  logic [CntW-1:0]   next_index;
  logic [IW-1:0]     clr_addr;

  logic [CntW-1:0]   n;
  logic              al;
  logic [CntW-1:0]   start;
  logic              pass;
  logic [VW-1:0]     curr;
  logic [VW-1:0]     ptr;
  logic [VW-1:0]     idx_d;
  logic              pend;
  logic [VW-1:0]     run;
  logic [VW-1:0]     found;
  logic [VW-1:0]     mark_k;

  // Shared remainder unit.
  logic [FrameW-1:0] div_q;
  logic [CntW-1:0]   div_r;
  logic [4:0]        div_cnt;
  logic [1:0]        div_ret;
  logic [CntW:0]     div_t;
  logic [CntW:0]     div_s;
  logic [CntW-1:0]   div_r_next;

  rsp_t              res;
  rsp_t              rsp_q;

  logic              mem [MAX_PAGES];
  logic              mem_we;
  logic [IW-1:0]     mem_wa;
  logic              mem_wd;
  logic              rd_q;

  logic [VW-1:0]     size;
  logic [VW-1:0]     nv;
  logic [VW-1:0]     run_inc;
  logic              hit;
  logic              pool_wr;

  assign size    = (VW'(pool_size) > MaxV) ? MaxV : VW'(pool_size);
  assign nv      = VW'(n);
  assign run_inc = run + VW'(1);
  assign hit     = pend && !rd_q && (run_inc >= nv);
  assign pool_wr = cfg_we && (cfg_index == CFG_POOL_SIZE);

  // One step of restoring remainder: shift in a dividend bit, subtract if it fits.
  assign div_t      = {div_r, div_q[FrameW-1]};
  assign div_s      = div_t - {1'b0, n};
  assign div_r_next = (div_t >= {1'b0, n}) ? div_s[CntW-1:0] : div_t[CntW-1:0];

  assign req_stall = (state != S_IDLE);
  assign rsp_data  = rsp_q;

  // The map is written by the clearing pass and by marking a granted run.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = 1'b0;
    if (state == S_CLR) begin
      mem_we = 1'b1;
    end else if (state == S_MARK) begin
      mem_we = 1'b1;
      mem_wa = IW'(found + mark_k);
      mem_wd = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[IW'(ptr)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      base_frame <= '0;
      pool_size  <= 13'd4096;
      free_pages <= CntW'((VW'(13'd4096) > MaxV) ? MaxV : VW'(13'd4096));
      next_index <= '0;
      clr_addr   <= '0;
      rsp_valid  <= 1'b0;
      pend       <= 1'b0;
    end else begin
      if ((state == S_OUT) && !pool_wr && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      if (cfg_we && (cfg_index == CFG_BASE_FRAME)) begin
        base_frame <= cfg_data;
      end

      if (pool_wr) begin
        // New pool: clear the map and restart the counters.
        pool_size  <= cfg_data[CntW-1:0];
        free_pages <= CntW'((VW'(cfg_data[CntW-1:0]) > MaxV) ? MaxV
                                                           : VW'(cfg_data[CntW-1:0]));
        next_index <= '0;
        clr_addr   <= '0;
        state      <= S_CLR;
      end else begin
        unique case (state)
          S_CLR: begin
            clr_addr <= clr_addr + IW'(1);
            if (clr_addr == LastAddr) begin
              state <= S_IDLE;
            end
          end

          S_IDLE: begin
            if (req_valid) begin
              n   <= req_data.page_count;
              al  <= req_data.want_aligned;
              if (req_data.page_count == '0) begin
                // A zero-page request succeeds and grants nothing.
                res   <= {1'b1, {(FrameW + 1){1'b0}}, {CntW{1'b0}}};
                state <= S_OUT;
              end else if (free_pages == '0) begin
                res   <= '0;
                state <= S_OUT;
              end else if (req_data.want_aligned) begin
                res     <= '0;
                div_q   <= base_frame;
                div_r   <= '0;
                div_cnt <= '0;
                div_ret <= R_START;
                state   <= S_MOD;
              end else begin
                res     <= '0;
                start   <= '0;
                div_q   <= FrameW'(next_index);
                div_r   <= '0;
                div_cnt <= '0;
                div_ret <= R_CURR;
                state   <= S_MOD;
              end
            end
          end

          S_MOD: begin
            if (div_cnt == 5'd31) begin
              unique case (div_ret)
                R_START: begin
                  start   <= div_r_next;
                  div_q   <= FrameW'(next_index) + FrameW'(div_r_next);
                  div_r   <= '0;
                  div_cnt <= '0;
                  div_ret <= R_CURR;
                end
                R_CURR: begin
                  curr  <= VW'(next_index) + VW'(div_r_next);
                  pass  <= 1'b0;
                  state <= S_SCAN0;
                end
                R_RUN: begin
                  if (div_r_next != '0) begin
                    // Misaligned hit: resume past it by the offset.
                    curr  <= found + VW'(div_r_next);
                    state <= S_SCAN0;
                  end else begin
                    mark_k <= '0;
                    state  <= S_MARK;
                  end
                end
                default: begin
                  state <= S_IDLE;
                end
              endcase
            end else begin
              div_q   <= div_q << 1;
              div_r   <= div_r_next;
              div_cnt <= div_cnt + 5'd1;
            end
          end

          S_SCAN0: begin
            ptr   <= curr;
            run   <= '0;
            pend  <= 1'b0;
            state <= S_SCAN;
          end

          S_SCAN: begin
            if (hit) begin
              found <= idx_d + VW'(1) - nv;
              pend  <= 1'b0;
              if (al) begin
                div_q   <= FrameW'(idx_d + VW'(1) - nv) + FrameW'(start);
                div_r   <= '0;
                div_cnt <= '0;
                div_ret <= R_RUN;
                state   <= S_MOD;
              end else begin
                mark_k <= '0;
                state  <= S_MARK;
              end
            end else if (!pend && (ptr >= size)) begin
              if (!pass) begin
                pass  <= 1'b1;
                curr  <= (al && (start != '0)) ? VW'(n - start) : '0;
                state <= S_SCAN0;
              end else begin
                state <= S_OUT;
              end
            end else begin
              if (pend) begin
                run <= rd_q ? '0 : run_inc;
              end
              if (ptr < size) begin
                pend  <= 1'b1;
                idx_d <= ptr;
                ptr   <= ptr + VW'(1);
              end else begin
                pend <= 1'b0;
              end
            end
          end

          S_MARK: begin
            mark_k <= mark_k + VW'(1);
            if (mark_k == nv - VW'(1)) begin
              free_pages <= free_pages - n;
              next_index <= CntW'(found + nv);
              res        <= {1'b1, {1'b0, base_frame} + (FrameW + 1)'(found), n};
              state      <= S_OUT;
            end
          end

          S_OUT: begin
            if (!rsp_valid || !rsp_stall) begin
              rsp_q <= res;
              state <= S_IDLE;
            end
          end

          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

/* sim/tb_bitmap_contiguous_page_allocator_unit.sv */
// Testbench for the contiguous page allocator: directed and random requests against a scoreboard.
module tb_bitmap_contiguous_page_allocator_unit;
  import bcpa_pkg::*;

  localparam int PoolMax = 4096;
  // Register indexes with no register behind them; writes there are dropped.
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  // Scoreboard: keeps its own copy of the map, the free count and the next-fit
  // index, works out the result of every accepted request and checks the
  // results in order.
  class alloc_scoreboard;
    bit          page_used[PoolMax];
    int unsigned free_count;
    int unsigned next_fit;
    int unsigned base_reg;
    int unsigned pool_reg;
    rsp_t        expected_rsp[$];
    int          errors;

    function int unsigned pool_pages();
      return (pool_reg > PoolMax) ? PoolMax : pool_reg;
    endfunction

    function void restart_pool();
      foreach (page_used[i]) page_used[i] = 1'b0;
      free_count = pool_pages();
      next_fit   = 0;
    endfunction

    function void reset_regs();
      base_reg = 0;
      pool_reg = PoolMax;
      restart_pool();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [FrameW-1:0] value);
      if (idx == CFG_BASE_FRAME) begin
        base_reg = value;
      end else if (idx == CFG_POOL_SIZE) begin
        pool_reg = value[CntW-1:0];
        restart_pool();
      end
    endfunction

    // Lowest start at or past from with n free pages inside the pool, or -1.
    function int find_free_run(int unsigned from, int unsigned n);
      int unsigned size;
      int unsigned run;
      size = pool_pages();
      run = 0;
      if (from >= size) return -1;
      for (int unsigned i = from; i < size; i++) begin
        if (page_used[i]) begin
          run = 0;
        end else begin
          run++;
          if (run >= n) return int'(i + 1 - n);
        end
      end
      return -1;
    endfunction

    function void note_request(req_t r);
      int unsigned n;
      int unsigned start;
      int unsigned curr;
      int unsigned found;
      bit          ok;
      int          b;
      rsp_t        e;
      n = r.page_count;
      e = '0;
      ok = 1'b0;
      found = 0;
      if (n == 0) begin
        // A request for nothing always succeeds and touches no state.
        e.granted = 1'b1;
        expected_rsp.push_back(e);
        return;
      end
      start = r.want_aligned ? base_reg % n : 0;
      curr = next_fit + ((next_fit + start) % n);
      for (int pass = 0; pass < 2 && !ok; pass++) begin
        while (free_count != 0) begin
          b = find_free_run(curr, n);
          if (b < 0) begin
            curr = r.want_aligned ? (n - (base_reg % n)) % n : 0;
            break;
          end
          if (r.want_aligned && (((b + start) % n) != 0)) begin
            curr = b + ((b + start) % n);
          end else begin
            found = b;
            ok = 1'b1;
            break;
          end
        end
      end
      if (ok) begin
        for (int unsigned k = 0; k < n; k++) page_used[found + k] = 1'b1;
        free_count -= n;
        next_fit = found + n;
        e.granted = 1'b1;
        e.first_frame = 33'(base_reg) + 33'(found);
        e.granted_count = n[CntW-1:0];
      end
      expected_rsp.push_back(e);
    endfunction

    function void check_result(rsp_t a);
      rsp_t e;
      if (expected_rsp.size() == 0) begin
        $error("unexpected result: granted=%0d first_frame=%0d granted_count=%0d",
               a.granted, a.first_frame, a.granted_count);
        errors++;
        return;
      end
      e = expected_rsp.pop_front();
      if (a.granted !== e.granted) begin
        $error("granted: expected %0d, got %0d", e.granted, a.granted);
        errors++;
      end
      if (a.first_frame !== e.first_frame) begin
        $error("first_frame: expected %0d, got %0d", e.first_frame, a.first_frame);
        errors++;
      end
      if (a.granted_count !== e.granted_count) begin
        $error("granted_count: expected %0d, got %0d", e.granted_count, a.granted_count);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  req_t               req_data = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  rsp_t               rsp_data;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CFG_BASE_FRAME;
  logic [FrameW-1:0]  cfg_data = '0;

  alloc_scoreboard sb = new();

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  bitmap_contiguous_page_allocator_unit #(.MAX_PAGES(PoolMax)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // The receiver picks a new stall value on every falling edge.
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Results are taken on the rising edge, before the block updates anything.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
  end

  // Drives one request, holds it until the block takes it, then maybe idles.
  task automatic send_request(int unsigned n, bit aligned);
    req_t r;
    r.page_count = n[CntW-1:0];
    r.want_aligned = aligned;
    @(negedge clk);
    req_valid <= 1'b1;
    req_data <= r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
  endtask

  // Waits until every expected result has arrived, then lets the block settle.
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Configuration is only written when no result is outstanding, though the map may still be clearing.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [FrameW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  // Mostly short runs so that the small pools see many grants before they fill;
  // sometimes runs of up to the whole pool or wildly oversized requests.
  function automatic int unsigned pick_count(int unsigned pool);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 4) return 0;
    if (sel < 75) return $urandom_range(8, 1);
    if (sel < 92) return $urandom_range(pool, 1);
    return $urandom_range(PoolMax, 1);
  endfunction

  initial begin
    int unsigned pool;
    sb.reset_regs();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part on the full default pool: zero pages, single pages, and
    // a run as large as the pool once part of it is taken.
    send_request(0, 1'b0);
    send_request(1, 1'b0);
    send_request(1, 1'b1);
    send_request(PoolMax, 1'b0);
    send_request(PoolMax, 1'b1);
    drain();

    // Highest base frame: an aligned full-pool run cannot be placed, an
    // unaligned one takes everything, so a following one-page request is refused.
    write_reg(CFG_BASE_FRAME, 32'hFFFF_FFFF);
    write_reg(CFG_POOL_SIZE, PoolMax);
    send_request(PoolMax, 1'b1);
    send_request(PoolMax, 1'b0);
    send_request(1, 1'b0);
    send_request(0, 1'b1);
    drain();

    // A pool size above the maximum is clipped to it.
    write_reg(CFG_POOL_SIZE, 32'h1FFF);
    send_request(32'h0FFF, 1'b0);
    send_request(2, 1'b0);
    drain();

    // An empty pool refuses everything but zero-page requests.
    write_reg(CFG_POOL_SIZE, 0);
    send_request(1, 1'b0);
    send_request(0, 1'b0);
    drain();

    // Writes to unused indexes are dropped, so the pool stays as it is.
    write_reg(CFG_SPARE_A, 32'h5);
    write_reg(CFG_SPARE_B, 32'hFFFF_FFFF);
    write_reg(CFG_POOL_SIZE, 1);
    send_request(1, 1'b0);
    send_request(1, 1'b0);
    send_request(2, 1'b1);
    drain();

    // Aligned runs against an odd base frame, then a run larger than the pool.
    write_reg(CFG_BASE_FRAME, 3);
    write_reg(CFG_POOL_SIZE, 64);
    send_request(3, 1'b1);
    send_request(4, 1'b1);
    send_request(5, 1'b1);
    send_request(65, 1'b0);
    drain();

    // Random phases: each sets up a fresh small pool and then sends requests into
    // it, under one of the idling patterns.
    for (int phase = 0; phase < 20; phase++) begin
      drain();
      set_idling(phase);
      if ($urandom_range(3) == 0) write_reg(CFG_BASE_FRAME, $urandom_range(15));
      else write_reg(CFG_BASE_FRAME, $urandom);
      pool = ($urandom_range(9) == 0) ? $urandom_range(256, 65) : $urandom_range(64, 1);
      write_reg(CFG_POOL_SIZE, pool);
      for (int i = 0; i < 96; i++) begin
        send_request(pick_count(pool), 1'($urandom_range(1)));
        // Now and then the pool is refilled mid-phase so it is not stuck full.
        if (i % 32 == 31) begin
          drain();
          write_reg(CFG_POOL_SIZE, pool);
        end
      end
    end

    drain();
    if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Safety net far above the slowest correct run.
  initial begin
    #(20 * 20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* bitmap_contiguous_page_allocator_unit.f */
rtl/bcpa_pkg.sv
rtl/bitmap_contiguous_page_allocator_unit.sv
sim/tb_bitmap_contiguous_page_allocator_unit.sv
